// File: src/rational_arithmetic_unit_assert.svh
// ----------------------------------------------------------------------------
// rational arithmetic unit assertion macros
// clocked property checks, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define RAU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define RAU_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`else
`define RAU_ASSERT(label, prop, msg)
`define RAU_ASSERT_IMPL(label, ante, cons, msg)
`endif

`endif

// File: src/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// types and constants of the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int unsigned WIDTH_DEF = 32;
    localparam int unsigned NUM_W     = 32;
    localparam int unsigned DEN_W     = 31;
    localparam int unsigned QUO_W     = 32;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } op_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_DIV0,
        ST_OVF
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_COMB,
        S_SIGN,
        S_CHECK,
        S_GCD,
        S_DIVN,
        S_DIVD,
        S_DONE
    } state_t;

endpackage

// File: src/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational arithmetic unit
// adds, subtracts, multiplies or divides two signed fractions and returns the
// result reduced to lowest terms, with divide by zero and overflow status
// ----------------------------------------------------------------------------
// One item is worked at a time; s_tready is high only while the unit is idle.
// An item runs through a shared 32x32 multiplier (two or three products), a
// sign and range check, a binary GCD loop on one shared subtractor and two
// 32-step restoring divisions on that same subtractor. An item that ends in
// divide by zero, overflow or a zero result skips the GCD loop and the
// divisions. Any other result passes through set-up, a GCD loop whose
// length depends on the operand values, the two divisions and the load of
// the output register. The result sits in an output register, so the next
// item is accepted while it waits.
// WIDTH sets the signed range the result numerator and denominator must fit.
// ----------------------------------------------------------------------------
`include "rational_arithmetic_unit_assert.svh"

module rational_arithmetic_unit #(
    parameter int unsigned WIDTH = rau_pkg::WIDTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // left_num[31:0], left_den[62:32], right_num[94:63], right_den[125:95]
    input  logic [127:0] s_tdata,
    // kind[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // result_num[31:0], result_den[62:32]
    output logic [63:0]  m_tdata,
    // status[1:0]
    output logic [1:0]   m_tuser
);

    localparam int unsigned NW    = rau_pkg::NUM_W;
    localparam int unsigned DW    = rau_pkg::DEN_W;
    localparam int unsigned QW    = rau_pkg::QUO_W;
    localparam int unsigned CNT_W = $clog2(QW);
    localparam int unsigned K_W   = $clog2(QW);
    localparam logic signed [63:0] RES_HI = (64'sd1 <<< (WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] RES_LO = -RES_HI - 64'sd1;
    localparam logic [CNT_W-1:0]   CNT_LAST = CNT_W'(QW - 1);

    rau_pkg::state_t  state_reg, state_next;
    rau_pkg::op_t     op_reg, op_next;
    logic signed [NW-1:0] ln_reg, ln_next, rn_reg, rn_next;
    logic [DW-1:0]    ld_reg, ld_next, rd_reg, rd_next;
    logic signed [63:0] p0_reg, p0_next, p1_reg, p1_next, den_reg, den_next;
    logic             neg_reg, neg_next;
    logic [QW-1:0]    mag_reg, mag_next;
    logic [DW-1:0]    dv_reg, dv_next;
    logic [QW-1:0]    a_reg, a_next, b_reg, b_next;
    logic [K_W-1:0]   k_reg, k_next;
    logic [QW-1:0]    g_reg, g_next, rem_reg, rem_next, quo_reg, quo_next;
    logic [QW-1:0]    qn_reg, qn_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NW-1:0]    res_num_reg, res_num_next;
    logic [DW-1:0]    res_den_reg, res_den_next;
    rau_pkg::status_t res_st_reg, res_st_next;
    logic [NW-1:0]    out_num_reg, out_num_next;
    logic [DW-1:0]    out_den_reg, out_den_next;
    rau_pkg::status_t out_st_reg, out_st_next;
    logic             out_valid_reg, out_valid_next;

    logic signed [NW-1:0] mul_a, mul_b;
    logic signed [63:0]   prod;
    logic [QW:0]          sub_a, sub_b;
    logic [QW+1:0]        sub_d;
    logic                 borrow;
    logic                 a_gt_b;
    logic                 gcd_done;
    logic                 in_accept;
    logic                 in_div0;
    logic                 chk_div0, chk_ovf, chk_zero;
    logic                 out_load;
    logic [QW-1:0]        quo_shift;

    assign in_accept = s_tvalid && s_tready;
    assign in_div0   = (rau_pkg::op_t'(s_tuser) == rau_pkg::OP_DIV) && (s_tdata[94:63] == '0);
    assign chk_div0  = (den_reg == 64'sd0);
    assign chk_ovf   = (p0_reg < RES_LO) || (p0_reg > RES_HI) || (den_reg > RES_HI);
    assign chk_zero  = (p0_reg == 64'sd0);
    assign a_gt_b    = (a_reg > b_reg);
    assign gcd_done  = (a_reg == b_reg);
    assign out_load  = (state_reg == rau_pkg::S_DONE) && (!out_valid_reg || m_tready);

    // shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            rau_pkg::S_MUL0: begin
                mul_a = ln_reg;
                mul_b = (op_reg == rau_pkg::OP_MUL) ? rn_reg : {1'b0, rd_reg};
            end
            rau_pkg::S_MUL1: begin
                mul_a = {1'b0, ld_reg};
                mul_b = (op_reg == rau_pkg::OP_DIV) ? rn_reg : {1'b0, rd_reg};
            end
            rau_pkg::S_MUL2: begin
                mul_a = rn_reg;
                mul_b = {1'b0, ld_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // shared subtractor
    always_comb begin
        sub_a = '0;
        sub_b = '0;
        unique case (state_reg)
            rau_pkg::S_GCD: begin
                sub_a = a_gt_b ? {1'b0, a_reg} : {1'b0, b_reg};
                sub_b = a_gt_b ? {1'b0, b_reg} : {1'b0, a_reg};
            end
            rau_pkg::S_DIVN, rau_pkg::S_DIVD: begin
                sub_a = {rem_reg, quo_reg[QW-1]};
                sub_b = {1'b0, g_reg};
            end
            default: begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
    end

    assign sub_d     = {1'b0, sub_a} - {1'b0, sub_b};
    assign borrow    = sub_d[QW+1];
    assign quo_shift = {quo_reg[QW-2:0], !borrow};

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rau_pkg::S_IDLE: begin
                if (in_accept) begin
                    state_next = in_div0 ? rau_pkg::S_DONE : rau_pkg::S_MUL0;
                end
            end
            rau_pkg::S_MUL0: begin
                state_next = rau_pkg::S_MUL1;
            end
            rau_pkg::S_MUL1: begin
                if (op_reg == rau_pkg::OP_ADD || op_reg == rau_pkg::OP_SUB) begin
                    state_next = rau_pkg::S_MUL2;
                end else begin
                    state_next = rau_pkg::S_SIGN;
                end
            end
            rau_pkg::S_MUL2: begin
                state_next = rau_pkg::S_COMB;
            end
            rau_pkg::S_COMB: begin
                state_next = rau_pkg::S_SIGN;
            end
            rau_pkg::S_SIGN: begin
                state_next = rau_pkg::S_CHECK;
            end
            rau_pkg::S_CHECK: begin
                if (chk_div0 || chk_ovf || chk_zero) begin
                    state_next = rau_pkg::S_DONE;
                end else begin
                    state_next = rau_pkg::S_GCD;
                end
            end
            rau_pkg::S_GCD: begin
                if (gcd_done) begin
                    state_next = rau_pkg::S_DIVN;
                end
            end
            rau_pkg::S_DIVN: begin
                if (cnt_reg == CNT_LAST) begin
                    state_next = rau_pkg::S_DIVD;
                end
            end
            rau_pkg::S_DIVD: begin
                if (cnt_reg == CNT_LAST) begin
                    state_next = rau_pkg::S_DONE;
                end
            end
            rau_pkg::S_DONE: begin
                if (out_load) begin
                    state_next = rau_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = rau_pkg::S_IDLE;
            end
        endcase
    end

    // datapath
    always_comb begin
        op_next      = op_reg;
        ln_next      = ln_reg;
        ld_next      = ld_reg;
        rn_next      = rn_reg;
        rd_next      = rd_reg;
        p0_next      = p0_reg;
        p1_next      = p1_reg;
        den_next     = den_reg;
        neg_next     = neg_reg;
        mag_next     = mag_reg;
        dv_next      = dv_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        k_next       = k_reg;
        g_next       = g_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        qn_next      = qn_reg;
        cnt_next     = cnt_reg;
        res_num_next = res_num_reg;
        res_den_next = res_den_reg;
        res_st_next  = res_st_reg;
        unique case (state_reg)
            rau_pkg::S_IDLE: begin
                if (in_accept) begin
                    op_next      = rau_pkg::op_t'(s_tuser);
                    ln_next      = s_tdata[31:0];
                    ld_next      = s_tdata[62:32];
                    rn_next      = s_tdata[94:63];
                    rd_next      = s_tdata[125:95];
                    res_num_next = '0;
                    res_den_next = '0;
                    res_st_next  = rau_pkg::ST_DIV0;
                end
            end
            rau_pkg::S_MUL0: begin
                p0_next = prod;
            end
            rau_pkg::S_MUL1: begin
                den_next = prod;
            end
            rau_pkg::S_MUL2: begin
                p1_next = prod;
            end
            rau_pkg::S_COMB: begin
                if (op_reg == rau_pkg::OP_SUB) begin
                    p0_next = p0_reg - p1_reg;
                end else begin
                    p0_next = p0_reg + p1_reg;
                end
            end
            rau_pkg::S_SIGN: begin
                if (den_reg[63]) begin
                    p0_next  = -p0_reg;
                    den_next = -den_reg;
                end
            end
            rau_pkg::S_CHECK: begin
                res_num_next = '0;
                res_den_next = '0;
                if (chk_div0) begin
                    res_st_next = rau_pkg::ST_DIV0;
                end else if (chk_ovf) begin
                    res_st_next = rau_pkg::ST_OVF;
                end else if (chk_zero) begin
                    res_den_next = DW'(1);
                    res_st_next  = rau_pkg::ST_OK;
                end else begin
                    neg_next = p0_reg[63];
                    mag_next = p0_reg[63] ? (~p0_reg[QW-1:0] + QW'(1)) : p0_reg[QW-1:0];
                    a_next   = p0_reg[63] ? (~p0_reg[QW-1:0] + QW'(1)) : p0_reg[QW-1:0];
                    b_next   = den_reg[QW-1:0];
                    dv_next  = den_reg[DW-1:0];
                    k_next   = '0;
                end
            end
            rau_pkg::S_GCD: begin
                if (gcd_done) begin
                    g_next   = a_reg << k_reg;
                    rem_next = '0;
                    quo_next = mag_reg;
                    cnt_next = '0;
                end else if (!a_reg[0] && !b_reg[0]) begin
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                    k_next = k_reg + K_W'(1);
                end else if (!a_reg[0]) begin
                    a_next = a_reg >> 1;
                end else if (!b_reg[0]) begin
                    b_next = b_reg >> 1;
                end else if (a_gt_b) begin
                    a_next = sub_d[QW-1:0];
                end else begin
                    b_next = sub_d[QW-1:0];
                end
            end
            rau_pkg::S_DIVN, rau_pkg::S_DIVD: begin
                rem_next = borrow ? sub_a[QW-1:0] : sub_d[QW-1:0];
                quo_next = quo_shift;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST) begin
                    rem_next = '0;
                    cnt_next = '0;
                    if (state_reg == rau_pkg::S_DIVN) begin
                        qn_next  = quo_shift;
                        quo_next = {1'b0, dv_reg};
                    end else begin
                        res_num_next = neg_reg ? (~qn_reg + NW'(1)) : qn_reg;
                        res_den_next = quo_shift[DW-1:0];
                        res_st_next  = rau_pkg::ST_OK;
                    end
                end
            end
            default: begin
                op_next = op_reg;
            end
        endcase
    end

    // output register
    always_comb begin
        out_num_next   = out_num_reg;
        out_den_next   = out_den_reg;
        out_st_next    = out_st_reg;
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_num_next   = res_num_reg;
            out_den_next   = res_den_reg;
            out_st_next    = res_st_reg;
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rau_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        ln_reg      <= ln_next;
        ld_reg      <= ld_next;
        rn_reg      <= rn_next;
        rd_reg      <= rd_next;
        p0_reg      <= p0_next;
        p1_reg      <= p1_next;
        den_reg     <= den_next;
        neg_reg     <= neg_next;
        mag_reg     <= mag_next;
        dv_reg      <= dv_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        k_reg       <= k_next;
        g_reg       <= g_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        qn_reg      <= qn_next;
        cnt_reg     <= cnt_next;
        res_num_reg <= res_num_next;
        res_den_reg <= res_den_next;
        res_st_reg  <= res_st_next;
        out_num_reg <= out_num_next;
        out_den_reg <= out_den_next;
        out_st_reg  <= out_st_next;
    end

    assign s_tready = (state_reg == rau_pkg::S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_den_reg, out_num_reg};
    assign m_tuser  = out_st_reg;

    `RAU_ASSERT_IMPL(a_fail_zeroed, m_tvalid && (m_tuser != rau_pkg::ST_OK), (m_tdata == '0), "failed transfer carries a non-zero fraction")
    `RAU_ASSERT_IMPL(a_ok_den, m_tvalid && (m_tuser == rau_pkg::ST_OK), (m_tdata[62:32] != '0), "ok transfer with zero denominator")
    `RAU_ASSERT_IMPL(a_gcd_nonzero, state_reg == rau_pkg::S_GCD, (a_reg != '0) && (b_reg != '0), "gcd operand reached zero")
    `RAU_ASSERT_IMPL(a_rem_bound, (state_reg == rau_pkg::S_DIVN) || (state_reg == rau_pkg::S_DIVD), (rem_reg < g_reg), "divider remainder not below divisor")

endmodule
